### sv/elevation_hole_fill_5x5_macros.svh
// Assertion macros used by the checker file.
`ifndef ELEVATION_HOLE_FILL_5X5_MACROS_SVH
`define ELEVATION_HOLE_FILL_5X5_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define EHF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define EHF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/ehf_pkg.sv
`default_nettype none
package ehf_pkg;
    localparam int MAX_COLS = 512;
    localparam int MAX_ROWS = 512;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int ADDR_W   = COL_W + ROW_W;
    localparam int DIM_W    = 10;
    localparam int CNT_W    = 19;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_FILL  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] REG_THRESH = 2'd0;
    localparam logic [1:0] REG_COLS   = 2'd1;
    localparam logic [1:0] REG_ROWS   = 2'd2;

    localparam logic signed [31:0] THRESH_RESET = -32'sd2560000;
    localparam logic [DIM_W-1:0]   DIM_RESET    = 10'd512;
endpackage
`default_nettype wire

### sv/ehf_divider.sv
`default_nettype none
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
module ehf_divider
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [39:0] dividend,
    input  wire logic [4:0]         divisor,
    output logic                    done,
    output logic signed [31:0]      quotient
);
    logic [39:0] mag_reg, mag_next;
    logic [39:0] rem_reg, rem_next;
    logic        neg_reg, neg_next;
    logic [5:0]  step_reg, step_next;
    logic        run_reg, run_next;
    logic [4:0]  dvs_reg, dvs_next;
    logic [40:0] trial;
    logic [39:0] qsigned;

    always_comb
    begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        run_next  = run_reg;
        dvs_next  = dvs_reg;
        done      = 1'b0;
        trial     = {rem_reg, mag_reg[39]} - {36'd0, dvs_reg};
        if (start)
        begin
            mag_next  = dividend[39] ? 40'(-dividend) : dividend;
            neg_next  = dividend[39];
            rem_next  = '0;
            step_next = '0;
            dvs_next  = divisor;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            // shift in one dividend bit, subtract when it fits
            if (!trial[40])
            begin
                rem_next = trial[39:0];
                mag_next = {mag_reg[38:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[38:0], mag_reg[39]};
                mag_next = {mag_reg[38:0], 1'b0};
            end
            step_next = step_reg + 6'd1;
            if (step_reg == 6'd39)
            begin
                run_next = 1'b0;
            end
        end
        else if (step_reg == 6'd40)
        begin
            done      = 1'b1;
            step_next = '0;
        end
    end

    assign qsigned  = neg_reg ? 40'(-mag_reg) : mag_reg;
    assign quotient = qsigned[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        dvs_reg <= dvs_next;
    end
endmodule
`default_nettype wire

### sv/elevation_hole_fill_5x5.sv
`default_nettype none
// Channel   | Signals                                  | Direction
// ----------+------------------------------------------+----------
// command   | start, kind, col, row, pixel_in; busy is out | in
// result    | done, pixel_out, filled_count            | out
// config    | cfg_we, cfg_index, cfg_data              | in
//
// A write or an unused kind runs S_ACC then S_DONE; a read adds S_RDOUT.
// A fill visits every pixel of the grid in use: a non-hole runs S_CRD, S_CCHK
// and S_NEXT; a hole also reads its 5x5 window in S_WRD, takes in the last
// window word in S_DIV and waits in S_STORE for the serial divider (skipped
// when no neighbor is valid), paced by the single-port grid memory.
// rst_n resets control, config and output state; grid memory stays undefined.
// The receiver cannot stall: done is high for one cycle per command.
module elevation_hole_fill_5x5
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     kind,
    input  wire logic [8:0]                     col,
    input  wire logic [8:0]                     row,
    input  wire logic signed [31:0]             pixel_in,
    output logic                                done,
    output logic signed [31:0]                  pixel_out,
    output logic [18:0]                         filled_count,
    input  wire logic                           cfg_we,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [31:0]                    cfg_data
);
    localparam int AW = ehf_pkg::ADDR_W;
    localparam int CW = ehf_pkg::COL_W;
    localparam int RW = ehf_pkg::ROW_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ACC    = 4'd1;  // write/read issue, fill setup
    localparam logic [3:0] S_RDOUT  = 4'd2;
    localparam logic [3:0] S_CRD    = 4'd3;  // fill: read center
    localparam logic [3:0] S_CCHK   = 4'd4;
    localparam logic [3:0] S_WRD    = 4'd5;  // fill: issue window read
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_STORE  = 4'd7;
    localparam logic [3:0] S_NEXT   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0] state_reg, state_next;

    logic signed [31:0]      thresh_reg;
    logic [ehf_pkg::DIM_W-1:0] cols_reg, rows_reg;

    logic [1:0]  kind_reg;
    logic [8:0]  col_reg, row_reg;
    logic signed [31:0] pin_reg;

    // fill position and window offsets
    logic [CW-1:0] fc_reg, fc_next;
    logic [RW-1:0] fr_reg, fr_next;
    logic [2:0]    dc_reg, dc_next;
    logic [2:0]    dr_reg, dr_next;
    logic          wpend_reg, wpend_next;
    logic signed [39:0] sum_reg, sum_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [18:0]   filled_reg, filled_next;

    // grid memory
    logic signed [31:0] grid_mem [0:(1<<AW)-1];
    logic signed [31:0] rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic signed [31:0] mem_wdata;

    logic [10:0] ncols, nrows;
    logic [10:0] wx, wy;
    logic        win_in;
    logic        div_start, div_done;
    logic signed [31:0] quot;
    logic        in_grid;
    logic signed [31:0] pout_reg;
    logic [18:0] fcnt_reg;
    logic        done_reg;

    assign ncols = (cols_reg > 10'(ehf_pkg::MAX_COLS)) ? 11'(ehf_pkg::MAX_COLS) : 11'(cols_reg);
    assign nrows = (rows_reg > 10'(ehf_pkg::MAX_ROWS)) ? 11'(ehf_pkg::MAX_ROWS) : 11'(rows_reg);
    assign in_grid = (11'(col_reg) < ncols) && (11'(row_reg) < nrows);

    // window position: offset in 0..4 stands for -2..+2
    assign wx = 11'(fc_reg) + 11'(dc_reg) - 11'd2;
    assign wy = 11'(fr_reg) + 11'(dr_reg) - 11'd2;
    assign win_in = !wx[10] && !wy[10] && (wx < ncols) && (wy < nrows);

    ehf_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (quot)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_addr] <= mem_wdata;
        end
        rd_data <= grid_mem[mem_addr];
    end

    always_comb
    begin
        state_next  = state_reg;
        fc_next     = fc_reg;
        fr_next     = fr_reg;
        dc_next     = dc_reg;
        dr_next     = dr_reg;
        wpend_next  = 1'b0;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        filled_next = filled_reg;
        mem_we      = 1'b0;
        mem_addr    = {fc_reg, fr_reg};
        mem_wdata   = quot;
        div_start   = 1'b0;

        // accumulate the window word read last cycle if above the threshold
        if (wpend_reg && (rd_data > thresh_reg))
        begin
            sum_next = sum_reg + 40'(rd_data);
            cnt_next = cnt_reg + 5'd1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                mem_addr  = {col_reg[CW-1:0], row_reg[RW-1:0]};
                mem_wdata = pin_reg;
                case (kind_reg)
                    ehf_pkg::KIND_WRITE:
                    begin
                        mem_we     = in_grid;
                        state_next = S_DONE;
                    end
                    ehf_pkg::KIND_READ:
                    begin
                        state_next = S_RDOUT;
                    end
                    ehf_pkg::KIND_FILL:
                    begin
                        fc_next     = '0;
                        fr_next     = '0;
                        filled_next = '0;
                        state_next  = (ncols == 11'd0 || nrows == 11'd0) ? S_DONE : S_CRD;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RDOUT:
            begin
                // hold the read address so the word is still there in S_DONE
                mem_addr   = {col_reg[CW-1:0], row_reg[RW-1:0]};
                state_next = S_DONE;
            end
            S_CRD:
            begin
                state_next = S_CCHK;
            end
            S_CCHK:
            begin
                if (rd_data < thresh_reg)
                begin
                    dc_next    = '0;
                    dr_next    = '0;
                    sum_next   = '0;
                    cnt_next   = '0;
                    state_next = S_WRD;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_WRD:
            begin
                mem_addr   = {wx[CW-1:0], wy[RW-1:0]};
                wpend_next = win_in;
                if (dr_reg == 3'd4)
                begin
                    dr_next = '0;
                    if (dc_reg == 3'd4)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        dc_next = dc_reg + 3'd1;
                    end
                end
                else
                begin
                    dr_next = dr_reg + 3'd1;
                end
            end
            S_DIV:
            begin
                // once the last window word is summed, divide if cnt_reg > 0
                if (!wpend_reg)
                begin
                    if (cnt_reg == 5'd0)
                    begin
                        state_next = S_STORE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_STORE;
                    end
                end
            end
            S_STORE:
            begin
                if (cnt_reg == 5'd0 || div_done)
                begin
                    mem_we      = 1'b1;
                    mem_wdata   = (cnt_reg == 5'd0) ? 32'sd0 : quot;
                    filled_next = (filled_reg == ehf_pkg::COUNT_MAX) ? filled_reg
                                  : filled_reg + 19'd1;
                    state_next  = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (11'(fr_reg) == nrows - 11'd1)
                begin
                    fr_next = '0;
                    if (11'(fc_reg) == ncols - 11'd1)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        fc_next    = fc_reg + CW'(1);
                        state_next = S_CRD;
                    end
                end
                else
                begin
                    fr_next    = fr_reg + RW'(1);
                    state_next = S_CRD;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            thresh_reg <= ehf_pkg::THRESH_RESET;
            cols_reg   <= ehf_pkg::DIM_RESET;
            rows_reg   <= ehf_pkg::DIM_RESET;
            done_reg   <= 1'b0;
            pout_reg   <= '0;
            fcnt_reg   <= '0;
            wpend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wpend_reg <= wpend_next;
            done_reg  <= (state_reg == S_DONE);
            if (cfg_we)
            begin
                case (cfg_index)
                    ehf_pkg::REG_THRESH: thresh_reg <= cfg_data;
                    ehf_pkg::REG_COLS:   cols_reg   <= cfg_data[ehf_pkg::DIM_W-1:0];
                    ehf_pkg::REG_ROWS:   rows_reg   <= cfg_data[ehf_pkg::DIM_W-1:0];
                    default:             ;
                endcase
            end
            if (state_reg == S_DONE)
            begin
                pout_reg <= (kind_reg == ehf_pkg::KIND_READ && in_grid) ? rd_data : 32'sd0;
                fcnt_reg <= (kind_reg == ehf_pkg::KIND_FILL) ? filled_reg : 19'd0;
            end
        end
    end

    // hold command payload and fill datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            kind_reg <= kind;
            col_reg  <= col;
            row_reg  <= row;
            pin_reg  <= pixel_in;
        end
        fc_reg     <= fc_next;
        fr_reg     <= fr_next;
        dc_reg     <= dc_next;
        dr_reg     <= dr_next;
        sum_reg    <= sum_next;
        cnt_reg    <= cnt_next;
        filled_reg <= filled_next;
    end

    // a read keeps rd_data valid in S_DONE because the read address is held
    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign pixel_out    = pout_reg;
    assign filled_count = fcnt_reg;
endmodule
`default_nettype wire

### sv/ehf_checker.sv
`default_nettype none
`include "elevation_hole_fill_5x5_macros.svh"
module ehf_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [31:0] pixel_out,
    input wire logic [18:0] filled_count
);
    `EHF_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `EHF_ASSERT_IMPL(a_done_after_busy, clk, rst_n, done, !busy)
    `EHF_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    `EHF_ASSERT_IMPL(a_one_field, clk, rst_n, done, pixel_out == 32'd0 || filled_count == 19'd0)
endmodule

bind elevation_hole_fill_5x5 ehf_checker u_ehf_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .pixel_out    (pixel_out),
    .filled_count (filled_count)
);
`default_nettype wire

### tb/sv/tb_top.sv
`default_nettype none
module tb_top;
    // Opcode with no function: the block answers with a zero result.
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int GRID_WORDS = ehf_pkg::MAX_COLS * ehf_pkg::MAX_ROWS;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int ITEM_GOAL = 1300;

    typedef struct packed {
        logic signed [31:0]        pixel;
        logic [ehf_pkg::CNT_W-1:0] count;
    } fill_result_t;

    // Scoreboard: mirrors the grid and the registers, predicts each result
    // at the moment its command transfer is accepted, and checks results in order.
    class fill_scoreboard;
        int                 grid_mirror [GRID_WORDS];
        longint             threshold;
        int unsigned        cols_cfg;
        int unsigned        rows_cfg;
        fill_result_t       pending_q [$];
        int                 errors;
        int                 checked;
        int                 fills_seen;
        int                 holes_seen;

        function new();
            threshold = longint'(ehf_pkg::THRESH_RESET);
            cols_cfg  = 512;
            rows_cfg  = 512;
            errors    = 0;
            checked   = 0;
            fills_seen = 0;
            holes_seen = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] data);
            if (idx == ehf_pkg::REG_THRESH)
                threshold = longint'($signed(data));
            else if (idx == ehf_pkg::REG_COLS)
                cols_cfg = data[ehf_pkg::DIM_W-1:0];
            else if (idx == ehf_pkg::REG_ROWS)
                rows_cfg = data[ehf_pkg::DIM_W-1:0];
        endfunction

        function int unsigned grid_cols();
            return (cols_cfg > ehf_pkg::MAX_COLS) ? ehf_pkg::MAX_COLS : cols_cfg;
        endfunction

        function int unsigned grid_rows();
            return (rows_cfg > ehf_pkg::MAX_ROWS) ? ehf_pkg::MAX_ROWS : rows_cfg;
        endfunction

        // In-place masked mean, column outer, row inner.
        function int unsigned hole_fill();
            int unsigned nc;
            int unsigned nr;
            int unsigned filled;
            longint sum;
            longint valid_n;
            longint x;
            longint y;
            int v;
            nc = grid_cols();
            nr = grid_rows();
            filled = 0;
            for (int c = 0; c < nc; c++) begin
                for (int r = 0; r < nr; r++) begin
                    if (longint'(grid_mirror[c * ehf_pkg::MAX_ROWS + r]) >= threshold)
                        continue;
                    sum = 0;
                    valid_n = 0;
                    for (int dc = -2; dc <= 2; dc++) begin
                        for (int dr = -2; dr <= 2; dr++) begin
                            x = c + dc;
                            y = r + dr;
                            if (x < 0 || y < 0 || x >= nc || y >= nr)
                                continue;
                            v = grid_mirror[x * ehf_pkg::MAX_ROWS + y];
                            if (longint'(v) > threshold) begin
                                sum += v;
                                valid_n++;
                            end
                        end
                    end
                    grid_mirror[c * ehf_pkg::MAX_ROWS + r] =
                        (valid_n > 0) ? int'(sum / valid_n) : 0;
                    if (filled < ehf_pkg::COUNT_MAX)
                        filled++;
                end
            end
            return filled;
        endfunction

        function void note_command(logic [1:0] k, logic [8:0] c, logic [8:0] r,
                                   logic signed [31:0] pix);
            fill_result_t res;
            bit in_grid;
            int unsigned n_filled;
            res = '0;
            in_grid = (c < grid_cols()) && (r < grid_rows());
            if (k == ehf_pkg::KIND_WRITE) begin
                if (in_grid)
                    grid_mirror[c * ehf_pkg::MAX_ROWS + r] = pix;
            end else if (k == ehf_pkg::KIND_FILL) begin
                n_filled = hole_fill();
                res.count = n_filled[ehf_pkg::CNT_W-1:0];
                fills_seen++;
                holes_seen += res.count;
            end else if (k == ehf_pkg::KIND_READ) begin
                if (in_grid)
                    res.pixel = grid_mirror[c * ehf_pkg::MAX_ROWS + r];
            end
            pending_q.push_back(res);
        endfunction

        function void check_result(logic signed [31:0] pix,
                                   logic [ehf_pkg::CNT_W-1:0] cnt);
            fill_result_t want;
            if (pending_q.size() == 0) begin
                $error("result with no command outstanding: pixel_out=%0d filled_count=%0d",
                       pix, cnt);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (pix !== want.pixel) begin
                $error("pixel_out mismatch: expected %0d, got %0d", want.pixel, pix);
                errors++;
            end
            if (cnt !== want.count) begin
                $error("filled_count mismatch: expected %0d, got %0d", want.count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         kind;
    logic [8:0]         col;
    logic [8:0]         row;
    logic signed [31:0] pixel_in;
    logic               done;
    logic signed [31:0] pixel_out;
    logic [18:0]        filled_count;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    fill_scoreboard     sb;
    // Tracks which grid words hold a value; reads and fill windows stay on them.
    bit                 written [GRID_WORDS];
    int                 items_sent;
    int                 idle_pct;
    int                 quiet_cycles;
    bit                 accepted_now;

    elevation_hole_fill_5x5 i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .col          (col),
        .row          (row),
        .pixel_in     (pixel_in),
        .done         (done),
        .pixel_out    (pixel_out),
        .filled_count (filled_count),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Check every result strobe; results cannot be held off.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(pixel_out, filled_count);
    end

    // Watchdog: count cycles with neither a command transfer nor a result.
    always @(posedge clk)
    begin
        if (!rst_n || done || accepted_now)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Present one command and hold it until the block takes it.
    task automatic send_cmd(logic [1:0] k, logic [8:0] c, logic [8:0] r,
                            logic signed [31:0] pix);
        start    <= 1'b1;
        kind     <= k;
        col      <= c;
        row      <= r;
        pixel_in <= pix;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        accepted_now = 1'b1;
        sb.note_command(k, c, r, pix);
        if (k == ehf_pkg::KIND_WRITE && c < sb.grid_cols() && r < sb.grid_rows())
            written[c * ehf_pkg::MAX_ROWS + r] = 1'b1;
        items_sent++;
        #1 accepted_now = 1'b0;
    endtask

    // Drop start for a random gap, as often as the current idle rate asks.
    task automatic maybe_idle();
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Drop start and hold until every outstanding result has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Pixel values clustered around the threshold so holes, valid pixels
    // and pixels equal to the threshold all show up.
    function automatic logic signed [31:0] pick_pixel();
        longint v;
        case ($urandom_range(5))
            0: v = sb.threshold;
            1: v = sb.threshold - 1;
            2: v = sb.threshold + 1;
            3: v = sb.threshold + $signed($urandom_range(20000)) - 10000;
            default: v = $signed($urandom());
        endcase
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic bit grid_complete();
        for (int c = 0; c < sb.grid_cols(); c++)
            for (int r = 0; r < sb.grid_rows(); r++)
                if (!written[c * ehf_pkg::MAX_ROWS + r])
                    return 1'b0;
        return 1'b1;
    endfunction

    // One configuration phase: set registers, load the grid, then random traffic.
    task automatic run_phase(logic [31:0] thr, logic [31:0] ncols, logic [31:0] nrows,
                             int n_random);
        int sel;
        logic [8:0] c;
        logic [8:0] r;
        drain();
        write_reg(ehf_pkg::REG_THRESH, thr);
        write_reg(ehf_pkg::REG_COLS, ncols);
        write_reg(ehf_pkg::REG_ROWS, nrows);
        for (int ci = 0; ci < sb.grid_cols(); ci++) begin
            for (int ri = 0; ri < sb.grid_rows(); ri++) begin
                send_cmd(ehf_pkg::KIND_WRITE, 9'(ci), 9'(ri), pick_pixel());
                maybe_idle();
            end
        end
        for (int n = 0; n < n_random; n++) begin
            idle_pct = (items_sent < ITEM_GOAL / 3) ? 12 :
                       (items_sent < 2 * ITEM_GOAL / 3) ? 55 : 0;
            sel = $urandom_range(99);
            // Mostly addresses inside the grid in use, some anywhere.
            if ($urandom_range(3) == 0) begin
                c = 9'($urandom());
                r = 9'($urandom());
            end else begin
                c = 9'($urandom_range(sb.grid_cols() - 1));
                r = 9'($urandom_range(sb.grid_rows() - 1));
            end
            if (sel < 12 && grid_complete())
                send_cmd(ehf_pkg::KIND_FILL, 9'($urandom()), 9'($urandom()), $urandom());
            else if (sel < 16)
                send_cmd(KIND_SPARE, c, r, $urandom());
            else if (sel < 60 && !(c < sb.grid_cols() && r < sb.grid_rows()
                                   && !written[c * ehf_pkg::MAX_ROWS + r]))
                send_cmd(ehf_pkg::KIND_READ, c, r, $urandom());
            else
                send_cmd(ehf_pkg::KIND_WRITE, c, r, pick_pixel());
            maybe_idle();
        end
        // Close each phase with a fill and a readback of the filled grid.
        send_cmd(ehf_pkg::KIND_FILL, 9'd0, 9'd0, 32'sd0);
        for (int k = 0; k < 4; k++)
            send_cmd(ehf_pkg::KIND_READ, 9'($urandom_range(sb.grid_cols() - 1)),
                     9'($urandom_range(sb.grid_rows() - 1)), 32'sd0);
    endtask

    initial
    begin
        int ph;
        sb = new();
        items_sent   = 0;
        idle_pct     = 12;
        accepted_now = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        kind      = ehf_pkg::KIND_WRITE;
        col       = '0;
        row       = '0;
        pixel_in  = '0;
        cfg_we    = 1'b0;
        cfg_index = ehf_pkg::REG_THRESH;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corner addresses and extreme values on the default grid.
        send_cmd(ehf_pkg::KIND_WRITE, 9'd0, 9'd0, 32'h8000_0000);
        send_cmd(ehf_pkg::KIND_WRITE, 9'd511, 9'd511, 32'h7fff_ffff);
        send_cmd(ehf_pkg::KIND_WRITE, 9'd511, 9'd0, -32'sd2560000);
        send_cmd(ehf_pkg::KIND_WRITE, 9'd0, 9'd511, 32'hffff_ffff);
        send_cmd(ehf_pkg::KIND_READ, 9'd0, 9'd0, 32'sd0);
        send_cmd(ehf_pkg::KIND_READ, 9'd511, 9'd511, 32'sd0);
        send_cmd(ehf_pkg::KIND_READ, 9'd511, 9'd0, 32'sd0);
        send_cmd(ehf_pkg::KIND_READ, 9'd0, 9'd511, 32'sd0);
        send_cmd(KIND_SPARE, 9'd511, 9'd511, 32'hffff_ffff);
        // Empty grid: fill does nothing, accesses fall outside.
        drain();
        write_reg(ehf_pkg::REG_COLS, 32'd0);
        send_cmd(ehf_pkg::KIND_FILL, 9'd0, 9'd0, 32'sd0);
        send_cmd(ehf_pkg::KIND_WRITE, 9'd0, 9'd0, 32'sd5);
        send_cmd(ehf_pkg::KIND_READ, 9'd0, 9'd0, 32'sd0);
        drain();
        write_reg(ehf_pkg::REG_COLS, 32'd512);
        send_cmd(ehf_pkg::KIND_READ, 9'd0, 9'd0, 32'sd0);

        // Saturating sizes and threshold extremes, then many tiny grids.
        run_phase(32'h8000_0000, 32'd1023, 32'd1, 20);
        run_phase(32'h7fff_ffff, 32'd1, 32'd600, 20);
        run_phase(32'h0000_0000, 32'd6, 32'd6, 30);
        ph = 0;
        while (items_sent < ITEM_GOAL) begin
            if (ph == 5) begin
                // Sender waits for every outstanding result before resuming.
                drain();
            end
            run_phase(($urandom_range(3) == 0) ? $urandom() : -32'sd2560000,
                      $urandom_range(1, 7), $urandom_range(1, 7), 40);
            ph++;
        end

        drain();
        repeat (50) @(posedge clk);
        if (sb.pending_q.size() != 0) begin
            $error("%0d results never arrived", sb.pending_q.size());
            sb.errors++;
        end
        $display("covered %0d commands, %0d results checked", items_sent, sb.checked);
        $display("%0d fills replaced %0d holes over %0d grid phases",
                 sb.fills_seen, sb.holes_seen, ph + 3);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
